FILE: hw/rtl/rsws_pkg.sv
// Shared types, constants and helpers for the reservation station wakeup/select block.
// No dependencies; every other file in hw/rtl refers to this package by scoped names.

package rsws_pkg;

  // Default configuration and fixed field widths
  localparam int unsigned EntriesDef  = 32;
  localparam int unsigned TagBitsDef  = 8;
  localparam int unsigned KindBitsDef = 5;
  localparam int unsigned DataW       = 32;
  localparam int unsigned OccW        = 6;
  localparam int unsigned ModeW       = 2;

  // Request modes; the unused code behaves as a plain tick
  typedef enum logic [ModeW-1:0] {
    MODE_TICK   = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_FLUSH  = 2'd2
  } mode_e;

  // One result broadcast, tag already zero-extended to operand width
  typedef struct packed {
    logic             valid;
    logic [DataW-1:0] tag;
    logic [DataW-1:0] value;
  } bus_t;

  // One source operand: a value when ready, else the producer tag
  typedef struct packed {
    logic             rdy;
    logic [DataW-1:0] value;
  } operand_t;

  // Capture a broadcast value into a pending operand whose tag matches
  function automatic operand_t wake(operand_t op, bus_t bus);
    operand_t res;
    res = op;
    if (!op.rdy && bus.valid && (op.value == bus.tag)) begin
      res.rdy   = 1'b1;
      res.value = bus.value;
    end
    return res;
  endfunction

endpackage

FILE: hw/rtl/rsws_prio.sv
// Fixed-priority picker: one-hot grant of the lowest set request bit.
// Depends on rsws_pkg only for the default of its WIDTH parameter.

module rsws_prio #(
  parameter int unsigned WIDTH = rsws_pkg::EntriesDef
) (
  input  logic [WIDTH-1:0] req_i,
  output logic [WIDTH-1:0] gnt_o,
  output logic             any_o
);

  // Grant the lowest request, mask everything above it
  always_comb begin
    logic found;
    found = 1'b0;
    gnt_o = '0;
    for (int unsigned i = 0; i < WIDTH; i++) begin
      if (req_i[i] && !found) begin
        gnt_o[i] = 1'b1;
        found    = 1'b1;
      end
    end
    any_o = found;
  end

endmodule

FILE: hw/rtl/rsws_entry.sv
// One reservation station entry: append write, two-bus wakeup and issue release.
// Depends on rsws_pkg for the operand and broadcast types and the wakeup helper.

module rsws_entry #(
  parameter int unsigned KIND_BITS = rsws_pkg::KindBitsDef,
  parameter int unsigned TAG_BITS  = rsws_pkg::TagBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic                          flush_i,
  input  logic                          alloc_i,
  input  logic                          issue_i,
  input  logic [KIND_BITS-1:0]          new_kind_i,
  input  logic [TAG_BITS-1:0]           new_dest_i,
  input  rsws_pkg::operand_t            new_a_i,
  input  rsws_pkg::operand_t            new_b_i,
  input  rsws_pkg::bus_t                bus1_i,
  input  rsws_pkg::bus_t                bus2_i,
  output logic                          busy_o,
  output logic                          ready_o,
  output logic [KIND_BITS-1:0]          kind_o,
  output logic [TAG_BITS-1:0]           dest_o,
  output logic [rsws_pkg::DataW-1:0]    a_o,
  output logic [rsws_pkg::DataW-1:0]    b_o
);

  logic                 busy_q, busy_d;
  logic [KIND_BITS-1:0] kind_q, kind_d;
  logic [TAG_BITS-1:0]  dest_q, dest_d;
  rsws_pkg::operand_t   a_q, a_d;
  rsws_pkg::operand_t   b_q, b_d;
  logic                 busy_now;

  // Merge the append, then apply bus 1 followed by bus 2
  always_comb begin
    busy_now = busy_q | alloc_i;
    kind_d   = alloc_i ? new_kind_i : kind_q;
    dest_d   = alloc_i ? new_dest_i : dest_q;
    a_d      = rsws_pkg::wake(rsws_pkg::wake(alloc_i ? new_a_i : a_q, bus1_i), bus2_i);
    b_d      = rsws_pkg::wake(rsws_pkg::wake(alloc_i ? new_b_i : b_q, bus1_i), bus2_i);
    busy_d   = busy_now & ~issue_i;
  end

  // Report the woken-up view to the selector
  assign busy_o  = busy_q;
  assign ready_o = busy_now & a_d.rdy & b_d.rdy;
  assign kind_o  = kind_d;
  assign dest_o  = dest_d;
  assign a_o     = a_d.value;
  assign b_o     = b_d.value;

  // Occupancy flag: clear on flush, advance on every other request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (flush_i) begin
      busy_q <= 1'b0;
    end else if (step_i) begin
      busy_q <= busy_d;
    end
  end

  // Payload: hold unless a request steps the station
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      kind_q <= kind_d;
      dest_q <= dest_d;
      a_q    <= a_d;
      b_q    <= b_d;
    end
  end

endmodule

FILE: hw/rtl/reservation_station_wakeup_select.sv
// Top level of the reservation station: request register, entry array, select, result register.
// Depends on rsws_pkg, rsws_prio and rsws_entry.
//
//   channel  | handshake              | payload
//   ---------+------------------------+---------------------------------------------
//   request  | start in, busy out     | mode_i, new_*_i, bus1_*_i, bus2_*_i
//   result   | done_o strobe, 1 cycle | issue_*_o, append_rejected_o, occupancy_o,
//            |                        | nearly_full_o
//
// One request per cycle; busy stays low. A request is captured in the request register
// at the accepting edge, the station steps in the following cycle (append, two-bus wakeup,
// pick of the lowest ready entry) and the result register shows it in the cycle after that.
// Reset clears all entry busy flags, the count, the request flag and the done flag.
// The receiver cannot stall; a result is shown for exactly one cycle.

module reservation_station_wakeup_select #(
  parameter int unsigned ENTRIES   = rsws_pkg::EntriesDef,
  parameter int unsigned TAG_BITS  = rsws_pkg::TagBitsDef,
  parameter int unsigned KIND_BITS = rsws_pkg::KindBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [rsws_pkg::ModeW-1:0]      mode_i,
  input  logic [KIND_BITS-1:0]            new_op_kind_i,
  input  logic [TAG_BITS-1:0]             new_dest_tag_i,
  input  logic                            new_a_ready_i,
  input  logic [rsws_pkg::DataW-1:0]      new_a_i,
  input  logic                            new_b_ready_i,
  input  logic [rsws_pkg::DataW-1:0]      new_b_i,
  input  logic [TAG_BITS:0]               bus1_tag_i,
  input  logic [rsws_pkg::DataW-1:0]      bus1_value_i,
  input  logic [TAG_BITS:0]               bus2_tag_i,
  input  logic [rsws_pkg::DataW-1:0]      bus2_value_i,
  output logic                            done_o,
  output logic                            issue_valid_o,
  output logic [KIND_BITS-1:0]            issue_op_kind_o,
  output logic [rsws_pkg::DataW-1:0]      issue_a_o,
  output logic [rsws_pkg::DataW-1:0]      issue_b_o,
  output logic [TAG_BITS-1:0]             issue_dest_tag_o,
  output logic                            append_rejected_o,
  output logic [rsws_pkg::OccW-1:0]       occupancy_o,
  output logic                            nearly_full_o
);

  localparam int unsigned CntW = $clog2(ENTRIES + 1);
  localparam int unsigned DataW = rsws_pkg::DataW;
  localparam int unsigned OccW  = rsws_pkg::OccW;

  // Request register
  logic                   req_q;
  logic [rsws_pkg::ModeW-1:0] mode_q;
  logic [KIND_BITS-1:0]   kind_q;
  logic [TAG_BITS-1:0]    dest_q;
  logic                   a_rdy_q, b_rdy_q;
  logic [DataW-1:0]       a_q, b_q;
  logic [TAG_BITS:0]      bus1_tag_q, bus2_tag_q;
  logic [DataW-1:0]       bus1_val_q, bus2_val_q;

  // Station step signals
  rsws_pkg::mode_e        mode;
  logic                   flush, step, append;
  rsws_pkg::bus_t         bus1, bus2;
  rsws_pkg::operand_t     new_a, new_b;
  logic [ENTRIES-1:0]     busy_vec, free_vec, ready_vec;
  logic [ENTRIES-1:0]     alloc_oh, issue_oh, alloc_vec, issue_vec;
  logic                   any_free, any_ready;
  logic [KIND_BITS-1:0]   ent_kind [ENTRIES];
  logic [TAG_BITS-1:0]    ent_dest [ENTRIES];
  logic [DataW-1:0]       ent_a    [ENTRIES];
  logic [DataW-1:0]       ent_b    [ENTRIES];
  logic [CntW-1:0]        cnt_q, cnt_d;

  // Result register
  logic                   done_q;
  logic                   valid_q, valid_d;
  logic [KIND_BITS-1:0]   res_kind_q, res_kind_d;
  logic [DataW-1:0]       res_a_q, res_a_d;
  logic [DataW-1:0]       res_b_q, res_b_d;
  logic [TAG_BITS-1:0]    res_dest_q, res_dest_d;
  logic                   rej_q, rej_d;
  logic [OccW-1:0]        occ_q, occ_d;
  logic                   nfull_q, nfull_d;

  assign busy = 1'b0;

  // Capture a request every cycle it is offered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q <= 1'b0;
    end else begin
      req_q <= start & ~busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      mode_q     <= mode_i;
      kind_q     <= new_op_kind_i;
      dest_q     <= new_dest_tag_i;
      a_rdy_q    <= new_a_ready_i;
      a_q        <= new_a_i;
      b_rdy_q    <= new_b_ready_i;
      b_q        <= new_b_i;
      bus1_tag_q <= bus1_tag_i;
      bus1_val_q <= bus1_value_i;
      bus2_tag_q <= bus2_tag_i;
      bus2_val_q <= bus2_value_i;
    end
  end

  // Decode the request mode
  always_comb begin
    mode   = rsws_pkg::mode_e'(mode_q);
    flush  = 1'b0;
    append = 1'b0;
    case (mode)
      rsws_pkg::MODE_FLUSH:  flush  = req_q;
      rsws_pkg::MODE_APPEND: append = req_q;
      rsws_pkg::MODE_TICK:   append = 1'b0;
      default:               append = 1'b0;
    endcase
    step = req_q & ~flush;
  end

  // Build the broadcasts and the new operands
  always_comb begin
    bus1.valid = ~bus1_tag_q[TAG_BITS];
    bus1.tag   = DataW'(bus1_tag_q[TAG_BITS-1:0]);
    bus1.value = bus1_val_q;
    bus2.valid = ~bus2_tag_q[TAG_BITS];
    bus2.tag   = DataW'(bus2_tag_q[TAG_BITS-1:0]);
    bus2.value = bus2_val_q;
    new_a.rdy   = a_rdy_q;
    new_a.value = a_q;
    new_b.rdy   = b_rdy_q;
    new_b.value = b_q;
  end

  // Lowest free entry takes the append
  assign free_vec = ~busy_vec;

  rsws_prio #(
    .WIDTH(ENTRIES)
  ) u_free_pick (
    .req_i(free_vec),
    .gnt_o(alloc_oh),
    .any_o(any_free)
  );

  assign alloc_vec = alloc_oh & {ENTRIES{append}};

  // Entry array
  for (genvar g = 0; g < ENTRIES; g++) begin : g_entry
    rsws_entry #(
      .KIND_BITS(KIND_BITS),
      .TAG_BITS (TAG_BITS)
    ) u_entry (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .step_i    (step),
      .flush_i   (flush),
      .alloc_i   (alloc_vec[g]),
      .issue_i   (issue_vec[g]),
      .new_kind_i(kind_q),
      .new_dest_i(dest_q),
      .new_a_i   (new_a),
      .new_b_i   (new_b),
      .bus1_i    (bus1),
      .bus2_i    (bus2),
      .busy_o    (busy_vec[g]),
      .ready_o   (ready_vec[g]),
      .kind_o    (ent_kind[g]),
      .dest_o    (ent_dest[g]),
      .a_o       (ent_a[g]),
      .b_o       (ent_b[g])
    );
  end

  // Lowest ready entry issues
  rsws_prio #(
    .WIDTH(ENTRIES)
  ) u_issue_pick (
    .req_i(ready_vec),
    .gnt_o(issue_oh),
    .any_o(any_ready)
  );

  assign issue_vec = issue_oh & {ENTRIES{step}};

  // Mux the issued entry out; zero when nothing issues
  always_comb begin
    res_kind_d = '0;
    res_dest_d = '0;
    res_a_d    = '0;
    res_b_d    = '0;
    for (int unsigned i = 0; i < ENTRIES; i++) begin
      res_kind_d = res_kind_d | (ent_kind[i] & {KIND_BITS{issue_vec[i]}});
      res_dest_d = res_dest_d | (ent_dest[i] & {TAG_BITS{issue_vec[i]}});
      res_a_d    = res_a_d    | (ent_a[i]    & {DataW{issue_vec[i]}});
      res_b_d    = res_b_d    | (ent_b[i]    & {DataW{issue_vec[i]}});
    end
    valid_d = step & any_ready;
  end

  // Track occupancy and flag a dropped append
  always_comb begin
    rej_d = append & ~any_free;
    if (flush) begin
      cnt_d = '0;
    end else if (step) begin
      cnt_d = cnt_q + CntW'(append & any_free) - CntW'(valid_d);
    end else begin
      cnt_d = cnt_q;
    end
    occ_d   = OccW'(cnt_d);
    nfull_d = ({1'b0, cnt_d} + (CntW + 1)'(1)) >= (CntW + 1)'(ENTRIES);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= req_q;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (req_q) begin
      valid_q    <= valid_d;
      res_kind_q <= res_kind_d;
      res_a_q    <= res_a_d;
      res_b_q    <= res_b_d;
      res_dest_q <= res_dest_d;
      rej_q      <= rej_d;
      occ_q      <= occ_d;
      nfull_q    <= nfull_d;
    end
  end

  assign done_o            = done_q;
  assign issue_valid_o     = valid_q;
  assign issue_op_kind_o   = res_kind_q;
  assign issue_a_o         = res_a_q;
  assign issue_b_o         = res_b_q;
  assign issue_dest_tag_o  = res_dest_q;
  assign append_rejected_o = rej_q;
  assign occupancy_o       = occ_q;
  assign nearly_full_o     = nfull_q;

endmodule

FILE: verif/reservation_station_wakeup_select_checker.sv
// Issue checker for the reservation station: predicts each request's result and compares it.
// Depends on rsws_pkg; instantiated beside the block by reservation_station_wakeup_select_tb.

module reservation_station_wakeup_select_checker
  import rsws_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   req_start_i,
  input  logic                   req_busy_i,
  input  logic [ModeW-1:0]       mode_i,
  input  logic [KindBitsDef-1:0] new_op_kind_i,
  input  logic [TagBitsDef-1:0]  new_dest_tag_i,
  input  logic                   new_a_ready_i,
  input  logic [DataW-1:0]       new_a_i,
  input  logic                   new_b_ready_i,
  input  logic [DataW-1:0]       new_b_i,
  input  logic [TagBitsDef:0]    bus1_tag_i,
  input  logic [DataW-1:0]       bus1_value_i,
  input  logic [TagBitsDef:0]    bus2_tag_i,
  input  logic [DataW-1:0]       bus2_value_i,
  input  logic                   rsp_done_i,
  input  logic                   issue_valid_i,
  input  logic [KindBitsDef-1:0] issue_op_kind_i,
  input  logic [DataW-1:0]       issue_a_i,
  input  logic [DataW-1:0]       issue_b_i,
  input  logic [TagBitsDef-1:0]  issue_dest_tag_i,
  input  logic                   append_rejected_i,
  input  logic [OccW-1:0]        occupancy_i,
  input  logic                   nearly_full_i,
  output int unsigned            mismatch_count_o,
  output int unsigned            outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Entries  = EntriesDef;
  localparam int unsigned TagBits  = TagBitsDef;
  localparam int unsigned KindBits = KindBitsDef;
  localparam int unsigned ReportMax = 10;

  typedef struct packed {
    logic                valid;
    logic [KindBits-1:0] kind;
    logic [DataW-1:0]    a;
    logic [DataW-1:0]    b;
    logic [TagBits-1:0]  dest;
    logic                rejected;
    logic [OccW-1:0]     occupancy;
    logic                nearly_full;
  } issue_rec_t;

  // Station image kept by the predictor
  logic                slot_busy  [Entries];
  logic [KindBits-1:0] slot_kind  [Entries];
  logic [TagBits-1:0]  slot_dest  [Entries];
  logic                slot_a_rdy [Entries];
  logic                slot_b_rdy [Entries];
  logic [DataW-1:0]    slot_a     [Entries];
  logic [DataW-1:0]    slot_b     [Entries];
  int unsigned         live_count;

  issue_rec_t  expected_issues[$];
  issue_rec_t  want;
  issue_rec_t  got;
  int unsigned err_count;

  // Wake every pending operand whose held tag matches a present broadcast
  task automatic broadcast_wake(input logic [TagBits:0] tag, input logic [DataW-1:0] value);
    logic [DataW-1:0] held_tag;
    held_tag = DataW'(tag[TagBits-1:0]);
    if (!tag[TagBits]) begin
      for (int i = 0; i < Entries; i++) begin
        if (!slot_a_rdy[i] && slot_a[i] == held_tag) begin
          slot_a_rdy[i] = 1'b1;
          slot_a[i]     = value;
        end
        if (!slot_b_rdy[i] && slot_b[i] == held_tag) begin
          slot_b_rdy[i] = 1'b1;
          slot_b[i]     = value;
        end
      end
    end
  endtask

  // Step the station image by one request and build the expected result
  task automatic step_station(output issue_rec_t rec);
    int slot;
    rec  = '0;
    slot = -1;
    if (mode_i == MODE_FLUSH) begin
      for (int i = 0; i < Entries; i++) slot_busy[i] = 1'b0;
      live_count = 0;
      return;
    end
    if (mode_i == MODE_APPEND) begin
      for (int i = Entries - 1; i >= 0; i--) begin
        if (!slot_busy[i]) slot = i;
      end
      if (slot < 0 || live_count >= Entries) begin
        rec.rejected = 1'b1;
      end else begin
        slot_busy[slot]  = 1'b1;
        slot_kind[slot]  = new_op_kind_i;
        slot_dest[slot]  = new_dest_tag_i;
        slot_a_rdy[slot] = new_a_ready_i;
        slot_a[slot]     = new_a_i;
        slot_b_rdy[slot] = new_b_ready_i;
        slot_b[slot]     = new_b_i;
        live_count++;
      end
    end
    broadcast_wake(bus1_tag_i, bus1_value_i);
    broadcast_wake(bus2_tag_i, bus2_value_i);
    // Select the lowest entry with both operands ready
    for (int i = 0; i < Entries; i++) begin
      if (slot_busy[i] && slot_a_rdy[i] && slot_b_rdy[i]) begin
        rec.valid    = 1'b1;
        rec.kind     = slot_kind[i];
        rec.a        = slot_a[i];
        rec.b        = slot_b[i];
        rec.dest     = slot_dest[i];
        slot_busy[i] = 1'b0;
        if (live_count > 0) live_count--;
        break;
      end
    end
    rec.occupancy   = OccW'(live_count);
    rec.nearly_full = (live_count + 1 >= Entries);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Entries; i++) begin
        slot_busy[i]  = 1'b0;
        slot_kind[i]  = '0;
        slot_dest[i]  = '0;
        slot_a_rdy[i] = 1'b0;
        slot_b_rdy[i] = 1'b0;
        slot_a[i]     = '0;
        slot_b[i]     = '0;
      end
      live_count = 0;
      expected_issues.delete();
      err_count = 0;
    end else begin
      // Compare a strobed result against the oldest expectation
      if (rsp_done_i) begin
        got = '{issue_valid_i, issue_op_kind_i, issue_a_i, issue_b_i, issue_dest_tag_i,
                append_rejected_i, occupancy_i, nearly_full_i};
        if (expected_issues.size() == 0) begin
          err_count++;
          if (err_count <= ReportMax) $display("%0t: result strobed with no request waiting", $time);
        end else begin
          want = expected_issues.pop_front();
          if (got !== want) begin
            err_count++;
            if (err_count <= ReportMax) begin
              $display("%0t: issue mismatch (expected/actual)", $time);
              $display("  valid %0b/%0b kind %0d/%0d dest %0d/%0d",
                       want.valid, got.valid, want.kind, got.kind, want.dest, got.dest);
              $display("  a %h/%h b %h/%h", want.a, got.a, want.b, got.b);
              $display("  rejected %0b/%0b occupancy %0d/%0d nearly_full %0b/%0b",
                       want.rejected, got.rejected, want.occupancy, got.occupancy,
                       want.nearly_full, got.nearly_full);
            end
          end
        end
      end
      // Predict each accepted request
      if (req_start_i && !req_busy_i) begin
        step_station(want);
        expected_issues.push_back(want);
      end
    end
    outstanding_o    = expected_issues.size();
    mismatch_count_o = err_count;
  end

endmodule

FILE: verif/reservation_station_wakeup_select_tb.sv
// Testbench top for the reservation station: clock, reset, request stimulus and verdict.
// Depends on rsws_pkg, the block itself and reservation_station_wakeup_select_checker.

module reservation_station_wakeup_select_tb;
  import rsws_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TagBits   = TagBitsDef;
  localparam int unsigned KindBits  = KindBitsDef;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned PhaseItems = 340;
  localparam int unsigned BlockItems = 60;
  localparam int unsigned TailCycles = 8;
  // Spare mode code; the block treats it as a plain tick
  localparam logic [ModeW-1:0]  ModeSpare = 2'd3;
  localparam logic [TagBits:0]  NoBus     = (TagBits + 1)'(1) << TagBits;

  // Traffic profiles for the random part
  typedef enum int {PROF_FILL, PROF_DRAIN, PROF_MIXED} profile_e;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [ModeW-1:0]    mode_i;
  logic [KindBits-1:0] new_op_kind_i;
  logic [TagBits-1:0]  new_dest_tag_i;
  logic                new_a_ready_i;
  logic [DataW-1:0]    new_a_i;
  logic                new_b_ready_i;
  logic [DataW-1:0]    new_b_i;
  logic [TagBits:0]    bus1_tag_i;
  logic [DataW-1:0]    bus1_value_i;
  logic [TagBits:0]    bus2_tag_i;
  logic [DataW-1:0]    bus2_value_i;
  logic                done_o;
  logic                issue_valid_o;
  logic [KindBits-1:0] issue_op_kind_o;
  logic [DataW-1:0]    issue_a_o;
  logic [DataW-1:0]    issue_b_o;
  logic [TagBits-1:0]  issue_dest_tag_o;
  logic                append_rejected_o;
  logic [OccW-1:0]     occupancy_o;
  logic                nearly_full_o;

  int unsigned mismatch_count;
  int unsigned outstanding;
  int unsigned cycle_count;

  reservation_station_wakeup_select uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .mode_i            (mode_i),
    .new_op_kind_i     (new_op_kind_i),
    .new_dest_tag_i    (new_dest_tag_i),
    .new_a_ready_i     (new_a_ready_i),
    .new_a_i           (new_a_i),
    .new_b_ready_i     (new_b_ready_i),
    .new_b_i           (new_b_i),
    .bus1_tag_i        (bus1_tag_i),
    .bus1_value_i      (bus1_value_i),
    .bus2_tag_i        (bus2_tag_i),
    .bus2_value_i      (bus2_value_i),
    .done_o            (done_o),
    .issue_valid_o     (issue_valid_o),
    .issue_op_kind_o   (issue_op_kind_o),
    .issue_a_o         (issue_a_o),
    .issue_b_o         (issue_b_o),
    .issue_dest_tag_o  (issue_dest_tag_o),
    .append_rejected_o (append_rejected_o),
    .occupancy_o       (occupancy_o),
    .nearly_full_o     (nearly_full_o)
  );

  reservation_station_wakeup_select_checker issue_chk (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .req_start_i       (start),
    .req_busy_i        (busy),
    .mode_i            (mode_i),
    .new_op_kind_i     (new_op_kind_i),
    .new_dest_tag_i    (new_dest_tag_i),
    .new_a_ready_i     (new_a_ready_i),
    .new_a_i           (new_a_i),
    .new_b_ready_i     (new_b_ready_i),
    .new_b_i           (new_b_i),
    .bus1_tag_i        (bus1_tag_i),
    .bus1_value_i      (bus1_value_i),
    .bus2_tag_i        (bus2_tag_i),
    .bus2_value_i      (bus2_value_i),
    .rsp_done_i        (done_o),
    .issue_valid_i     (issue_valid_o),
    .issue_op_kind_i   (issue_op_kind_o),
    .issue_a_i         (issue_a_o),
    .issue_b_i         (issue_b_o),
    .issue_dest_tag_i  (issue_dest_tag_o),
    .append_rejected_i (append_rejected_o),
    .occupancy_i       (occupancy_o),
    .nearly_full_i     (nearly_full_o),
    .mismatch_count_o  (mismatch_count),
    .outstanding_o     (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("reservation_station_wakeup_select_tb failed");
      $finish;
    end
  end

  // Present one request and hold it until accepted
  task automatic send_request(input logic [ModeW-1:0] mode, input logic [KindBits-1:0] kind,
                              input logic [TagBits-1:0] dest,
                              input logic a_rdy, input logic [DataW-1:0] a,
                              input logic b_rdy, input logic [DataW-1:0] b,
                              input logic [TagBits:0] t1, input logic [DataW-1:0] v1,
                              input logic [TagBits:0] t2, input logic [DataW-1:0] v2);
    @(negedge clk_i);
    start          <= 1'b1;
    mode_i         <= mode;
    new_op_kind_i  <= kind;
    new_dest_tag_i <= dest;
    new_a_ready_i  <= a_rdy;
    new_a_i        <= a;
    new_b_ready_i  <= b_rdy;
    new_b_i        <= b;
    bus1_tag_i     <= t1;
    bus1_value_i   <= v1;
    bus2_tag_i     <= t2;
    bus2_value_i   <= v2;
    do @(posedge clk_i); while (busy);
  endtask

  // Drop start for a number of cycles, with noise on the payload
  task automatic hold_off(input int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      start        <= 1'b0;
      mode_i       <= ModeW'($urandom);
      new_a_i      <= $urandom;
      bus1_tag_i   <= (TagBits + 1)'($urandom);
      bus1_value_i <= $urandom;
    end
  endtask

  // Hold off until every request has returned its result
  task automatic wait_drained();
    @(negedge clk_i);
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
  endtask

  // Pick a pending operand tag, mostly from a small pool so broadcasts hit
  function automatic logic [DataW-1:0] pending_tag();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 85) return DataW'($urandom_range(15));
    if (r < 95) return DataW'($urandom_range(255));
    return $urandom;
  endfunction

  function automatic logic [TagBits:0] pick_bus(input int unsigned pct);
    if ($urandom_range(99) >= pct) return NoBus;
    if ($urandom_range(9) == 0) return (TagBits + 1)'($urandom_range(255));
    return (TagBits + 1)'($urandom_range(15));
  endfunction

  initial begin
    int unsigned    idle_pct;
    int unsigned    app_pct;
    int unsigned    rdy_pct;
    int unsigned    bus_pct;
    int unsigned    r;
    profile_e       prof;
    logic [ModeW-1:0] mode;
    logic           a_rdy;
    logic           b_rdy;

    rst_ni         = 1'b0;
    start          = 1'b0;
    mode_i         = MODE_TICK;
    new_op_kind_i  = '0;
    new_dest_tag_i = '0;
    new_a_ready_i  = 1'b0;
    new_a_i        = '0;
    new_b_ready_i  = 1'b0;
    new_b_i        = '0;
    bus1_tag_i     = NoBus;
    bus1_value_i   = '0;
    bus2_tag_i     = NoBus;
    bus2_value_i   = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty ticks, spare mode, field extremes
    send_request(MODE_TICK, '0, '0, 1'b0, '0, 1'b0, '0, NoBus, '0, NoBus, '0);
    send_request(ModeSpare, '1, '1, 1'b1, '1, 1'b1, '1, NoBus, '1, NoBus, '1);
    send_request(MODE_APPEND, '1, '1, 1'b1, '1, 1'b1, '1, NoBus, '0, NoBus, '0);
    send_request(MODE_APPEND, '0, '0, 1'b1, '0, 1'b1, '0, NoBus, '0, NoBus, '0);
    // Wake an entry appended in the same tick
    send_request(MODE_APPEND, 5'd3, 8'd17, 1'b0, 32'd5, 1'b1, 32'h1234_5678,
                 9'd5, 32'hdead_beef, NoBus, '0);
    send_request(MODE_APPEND, 5'd4, 8'd18, 1'b0, 32'd7, 1'b0, 32'd9,
                 9'd7, 32'h0bad_cafe, 9'd9, 32'hfeed_f00d);
    // Both operands wait on one tag: bus 1 wins, bus 2 sees them ready
    send_request(MODE_APPEND, 5'd5, 8'd19, 1'b0, 32'd3, 1'b0, 32'd3,
                 9'd3, 32'h1111_1111, 9'd3, 32'h2222_2222);
    // Park entries: top tag, a held value no tag reaches, a wide held value
    send_request(MODE_APPEND, 5'd6, 8'd20, 1'b0, 32'd255, 1'b0, 32'hffff_ffff,
                 NoBus, '0, NoBus, '0);
    send_request(MODE_APPEND, 5'd7, 8'd21, 1'b0, 32'h0000_0100, 1'b1, 32'd1,
                 9'd0, 32'h3333_3333, NoBus, '0);
    send_request(MODE_TICK, '0, '0, 1'b0, '0, 1'b0, '0, 9'd255, 32'h4444_4444, NoBus, '0);
    // Append into the lowest free entry and wake it from bus 2
    send_request(MODE_APPEND, 5'd8, 8'd22, 1'b1, 32'h5555_5555, 1'b0, 32'd12,
                 NoBus, '0, 9'd12, 32'h6666_6666);
    send_request(MODE_FLUSH, '1, '1, 1'b1, '1, 1'b1, '1, 9'd0, '1, 9'd0, '1);
    send_request(MODE_APPEND, 5'd9, 8'd23, 1'b1, 32'h7777_7777, 1'b1, 32'h8888_8888,
                 NoBus, '0, NoBus, '0);
    wait_drained();

    // Random: three sender idling regimes, blocks of traffic profiles
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 10 : (phase == 1) ? 65 : 0;
      for (int n = 0; n < PhaseItems; n++) begin
        if (n % BlockItems == 0) begin
          prof = (n == 0) ? PROF_FILL : profile_e'($urandom_range(2));
          case (prof)
            PROF_FILL: begin
              app_pct = 90; rdy_pct = 20; bus_pct = 5;
            end
            PROF_DRAIN: begin
              app_pct = 20; rdy_pct = 80; bus_pct = 85;
            end
            default: begin
              app_pct = 55; rdy_pct = 50; bus_pct = 45;
            end
          endcase
        end
        r = $urandom_range(99);
        if (r < 2 && prof != PROF_FILL) mode = MODE_FLUSH;
        else if (r < 5) mode = ModeSpare;
        else if ($urandom_range(99) < app_pct) mode = MODE_APPEND;
        else mode = MODE_TICK;
        a_rdy = ($urandom_range(99) < rdy_pct);
        b_rdy = ($urandom_range(99) < rdy_pct);
        send_request(mode, KindBits'($urandom), TagBits'($urandom),
                     a_rdy, a_rdy ? $urandom : pending_tag(),
                     b_rdy, b_rdy ? $urandom : pending_tag(),
                     pick_bus(bus_pct), $urandom, pick_bus(bus_pct), $urandom);
        // Idle each following cycle with the phase's probability
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) hold_off(1);
      end
      wait_drained();
    end

    repeat (TailCycles) @(negedge clk_i);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("reservation_station_wakeup_select_tb passed");
    end else begin
      $display("reservation_station_wakeup_select_tb failed");
    end
    $finish;
  end

endmodule
